// ===== hw/rtl/iis_pkg.sv =====
// Shared widths, register codes and pipeline types for the integral image core.
`default_nettype none

package iis_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 28;
  localparam int SQ_W      = 36;
  localparam int IDX_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_WIDTH_DEFAULT  = 1024;
  localparam int MAX_HEIGHT_DEFAULT = 1024;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position and framing flags of one pixel as it moves down the pipeline.
  typedef struct packed {
    logic             first_row;
    logic             frame_end;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
  } iis_pos_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iis_pixel_if.sv =====
// Valid/ready channel that carries one input pixel.
`default_nettype none

interface iis_pixel_if import iis_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/iis_result_if.sv =====
// Valid/ready channel that carries one integral image result.
`default_nettype none

interface iis_result_if import iis_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] area_sum;
  logic [SQ_W-1:0]  area_sum_squares;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  logic             frame_end;

  modport source (output valid, output area_sum, output area_sum_squares,
                  output row_index, output col_index, output frame_end, input ready);
  modport sink (input valid, input area_sum, input area_sum_squares,
                input row_index, input col_index, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/iis_scan.sv =====
// Raster position counters and running row sums for the incoming pixel.
`default_nettype none

module iis_scan import iis_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT,
  localparam int CW     = $clog2(MAX_WIDTH),
  localparam int RW     = $clog2(MAX_HEIGHT),
  localparam int RUN_W  = PIX_W + CW,
  localparam int RSQ_W  = 2 * PIX_W + CW,
  localparam int PROD_W = 2 * PIX_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [PIX_W-1:0] pixel,
  input  logic [CFG_W-1:0] image_width,
  input  logic [CFG_W-1:0] image_height,
  output logic [CW-1:0]    addr,
  output iis_pos_t         pos,
  output logic [RUN_W-1:0] run_sum,
  output logic [RSQ_W-1:0] run_sumsq
);

  localparam logic [CW:0] W_MAX = (CW+1)'(MAX_WIDTH);
  localparam logic [RW:0] H_MAX = (RW+1)'(MAX_HEIGHT);

  logic [CW-1:0]    col, col_next;
  logic [RW-1:0]    row, row_next;
  logic [RUN_W-1:0] run, run_next;
  logic [RSQ_W-1:0] runsq, runsq_next;

  logic [CW:0]       w;
  logic [RW:0]       h;
  logic              wrap_in, wrap_out;
  logic [CW-1:0]     col_eff;
  logic [RW:0]       row_t;
  logic [RW-1:0]     row_eff;
  logic [CW:0]       col_inc;
  logic [RW:0]       row_inc;
  logic [PROD_W-1:0] pix_sq;

  // Width and height in use are the registers clamped to one through the maximum.
  always_comb begin
    if (image_width == '0) begin
      w = {{CW{1'b0}}, 1'b1};
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = W_MAX;
    end else begin
      w = (CW+1)'(image_width);
    end
    if (image_height == '0) begin
      h = {{RW{1'b0}}, 1'b1};
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h = H_MAX;
    end else begin
      h = (RW+1)'(image_height);
    end
  end

  // A narrower width written mid-frame can leave the column past the end,
  // in which case this pixel opens a new row first.
  assign wrap_in = {1'b0, col} >= w;
  assign col_eff = wrap_in ? '0 : col;
  assign row_t   = {1'b0, row} + {{RW{1'b0}}, wrap_in};
  assign row_eff = (row_t >= h) ? '0 : row_t[RW-1:0];

  assign pix_sq    = PROD_W'(pixel) * PROD_W'(pixel);
  assign run_sum   = (wrap_in ? '0 : run) + RUN_W'(pixel);
  assign run_sumsq = (wrap_in ? '0 : runsq) + RSQ_W'(pix_sq);

  assign col_inc  = {1'b0, col_eff} + {{CW{1'b0}}, 1'b1};
  assign row_inc  = {1'b0, row_eff} + {{RW{1'b0}}, 1'b1};
  assign wrap_out = col_inc >= w;

  always_comb begin
    if (wrap_out) begin
      col_next   = '0;
      run_next   = '0;
      runsq_next = '0;
      row_next   = (row_inc >= h) ? '0 : row_inc[RW-1:0];
    end else begin
      col_next   = col_inc[CW-1:0];
      run_next   = run_sum;
      runsq_next = run_sumsq;
      row_next   = row_eff;
    end
  end

  assign addr          = col_eff;
  assign pos.first_row = (row_eff == '0);
  assign pos.frame_end = ({1'b0, row_eff} == h - 1'b1) && ({1'b0, col_eff} == w - 1'b1);
  assign pos.row_index = IDX_W'(row_eff);
  assign pos.col_index = IDX_W'(col_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      run   <= '0;
      runsq <= '0;
    end else if (take) begin
      col   <= col_next;
      row   <= row_next;
      run   <= run_next;
      runsq <= runsq_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iis_linebuf.sv =====
// Line buffer of the previous row's integral values with read-modify-write.
`default_nettype none

module iis_linebuf import iis_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int RUN_W = PIX_W + CW,
  localparam int RSQ_W = 2 * PIX_W + CW
) (
  input  logic             clk,
  input  logic             load,
  input  logic             advance,
  input  logic [CW-1:0]    addr,
  input  logic             first_row,
  input  logic [RUN_W-1:0] run_sum,
  input  logic [RSQ_W-1:0] run_sumsq,
  output logic [SUM_W-1:0] area_sum,
  output logic [SQ_W-1:0]  area_sum_squares
);

  logic [SUM_W-1:0] mem_sum [MAX_WIDTH];
  logic [SQ_W-1:0]  mem_sq  [MAX_WIDTH];

  logic [SUM_W-1:0] q_sum, fwd_sum, above_sum;
  logic [SQ_W-1:0]  q_sq, fwd_sq, above_sq;
  logic             fwd;
  logic [CW-1:0]    s1_addr;
  logic             s1_first;
  logic [RUN_W-1:0] s1_run;
  logic [RSQ_W-1:0] s1_runsq;

  // When the item leaving writes the entry the new item reads in the same
  // cycle, the read returns stale data, so the written value is kept aside.
  always_ff @(posedge clk) begin
    if (advance) begin
      mem_sum[s1_addr] <= area_sum;
      mem_sq[s1_addr]  <= area_sum_squares;
    end
    if (load) begin
      q_sum    <= mem_sum[addr];
      q_sq     <= mem_sq[addr];
      fwd      <= advance && (s1_addr == addr);
      fwd_sum  <= area_sum;
      fwd_sq   <= area_sum_squares;
      s1_addr  <= addr;
      s1_first <= first_row;
      s1_run   <= run_sum;
      s1_runsq <= run_sumsq;
    end
  end

  always_comb begin
    if (s1_first) begin
      above_sum = '0;
      above_sq  = '0;
    end else if (fwd) begin
      above_sum = fwd_sum;
      above_sq  = fwd_sq;
    end else begin
      above_sum = q_sum;
      above_sq  = q_sq;
    end
  end

  assign area_sum         = above_sum + SUM_W'(s1_run);
  assign area_sum_squares = above_sq + SQ_W'(s1_runsq);

endmodule

`default_nettype wire

// ===== hw/rtl/integral_image_sum_sumsq_core.sv =====
// Integral image core: per-pixel summed-area and summed-square-area of a raster stream.
// A transferred pixel passes the line buffer stage and then the output register.
// Throughput: one pixel per cycle unless the output stalls; the line buffer takes one
// read and one write per cycle, forwarding the write when a row is one pixel wide.
// Reset clears the counters, running sums and pipeline; width and height return
// to 1024. The line buffer is not cleared, since the first row never reads it.
`default_nettype none

module integral_image_sum_sumsq_core import iis_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int RUN_W = PIX_W + CW,
  localparam int RSQ_W = 2 * PIX_W + CW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_enable,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [CFG_W-1:0]     write_data,
  iis_pixel_if.sink            pixels,
  iis_result_if.source         results
);

  logic [CFG_W-1:0] image_width, image_height;
  logic             accept, advance, s1_valid;
  iis_pos_t         scan_pos, s1_pos;
  logic [CW-1:0]    rd_addr;
  logic [RUN_W-1:0] run_sum;
  logic [RSQ_W-1:0] run_sumsq;
  logic [SUM_W-1:0] lb_sum;
  logic [SQ_W-1:0]  lb_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (write_enable) begin
      case (cfg_reg_t'(write_index))
        REG_IMAGE_WIDTH:  image_width  <= write_data;
        REG_IMAGE_HEIGHT: image_height <= write_data;
        default: ;
      endcase
    end
  end

  // The buffer stage moves on whenever the output register is free or drains.
  assign advance      = s1_valid && (!results.valid || results.ready);
  assign pixels.ready = !s1_valid || advance;
  assign accept       = pixels.valid && pixels.ready;

  iis_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .take         (accept),
    .pixel        (pixels.pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .addr         (rd_addr),
    .pos          (scan_pos),
    .run_sum      (run_sum),
    .run_sumsq    (run_sumsq)
  );

  iis_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk              (clk),
    .load             (accept),
    .advance          (advance),
    .addr             (rd_addr),
    .first_row        (scan_pos.first_row),
    .run_sum          (run_sum),
    .run_sumsq        (run_sumsq),
    .area_sum         (lb_sum),
    .area_sum_squares (lb_sq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos <= scan_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.area_sum         <= lb_sum;
      results.area_sum_squares <= lb_sq;
      results.row_index        <= s1_pos.row_index;
      results.col_index        <= s1_pos.col_index;
      results.frame_end        <= s1_pos.frame_end;
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not reach the line buffer stage");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> results.valid)
    else $error("line buffer stage advanced without producing a result");

  a_first_row_is_row_zero: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_pos.first_row |-> s1_pos.row_index == '0)
    else $error("first row flag set on a nonzero row");

  a_frame_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && scan_pos.frame_end |=> scan_pos.first_row && scan_pos.col_index == '0)
    else $error("scan did not return to the origin after the last pixel of a frame");

endmodule

`default_nettype wire
